// ----- hdl/bf128m_pkg.sv -----
// shared types, constants and helpers for the binary128 multiplier
package bf128m_pkg;

   localparam int NSTAGE = 9;
   localparam int EXP_W = 18;

   localparam logic [14:0] EXP_MAX = 15'h7FFF;
   localparam logic signed [EXP_W-1:0] EXP_BIAS = 18'sd16383;
   localparam logic signed [EXP_W-1:0] EXP_INF = 18'sd32767;
   localparam logic signed [EXP_W-1:0] EXP_TINY = -18'sd112;
   localparam logic [127:0] INF_VAL = {16'h7FFF, 112'd0};
   localparam logic [127:0] QNAN_VAL = {16'h7FFF, 1'b1, 111'd0};
   localparam logic [15:0] HALF_ULP = 16'h8000;

   typedef struct packed {
      logic sign;
      logic spec;
      logic [127:0] spec_val;
   } carry_type;

   function automatic logic [6:0] lead_zeros(input logic [127:0] v);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < 128; i++) begin
         if (v[i]) begin
            n = 7'(127 - i);
         end
      end
      return n;
   endfunction

endpackage

// ----- hdl/binary128_float_multiply.sv -----
// pipelined binary128 multiplier, round to nearest even
// throughput: one transaction per cycle while the output is not stalled, set by the
//    nine-stage pipeline of sixteen 32x32 partial-product multipliers, adder
//    stages and a rounding stage
// stages advance independently, so bubbles close up while the output stalls
// reset (synchronous, active high) clears all stage valid bits
module binary128_float_multiply (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [255:0] req_tdata,  // a_hi, a_lo, b_hi, b_lo
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [127:0] rsp_tdata   // product_hi, product_lo
);
   import bf128m_pkg::*;

   logic [NSTAGE:1] v_ff;
   logic [NSTAGE:1] en;
   carry_type c_ff [NSTAGE:1];

   logic [127:0] s1_ma_ff, s1_mb_ff;
   logic [6:0] s1_lza_ff, s1_lzb_ff;
   logic signed [EXP_W-1:0] s1_ea_ff, s1_eb_ff;
   logic [127:0] s2_x_ff, s2_y_ff;
   logic signed [EXP_W-1:0] s2_e_ff, s3_e_ff, s4_e_ff, s5_e_ff, s6_e_ff, s7_e_ff;
   logic [63:0] s3_pp_ff [4][4];
   logic [65:0] s4_col_ff [7];
   logic [255:0] s5_even_ff, s5_odd_ff, s6_z_ff;
   logic [127:0] s7_sig_ff;
   logic [127:0] s8_r_ff;
   logic s8_inc_ff;
   logic [127:0] s9_r_ff;

   always_comb begin
      en[NSTAGE] = !v_ff[NSTAGE] || rsp_tready;
      for (int k = NSTAGE - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end
   assign req_tready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) begin
            v_ff[1] <= req_tvalid;
         end
         for (int k = 2; k <= NSTAGE; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // stage 1: classify and count leading zeros
   logic [14:0] a_exp, b_exp;
   logic [111:0] a_frac, b_frac;
   logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [127:0] ma_in, mb_in;
   logic [6:0] lza_in, lzb_in;
   carry_type c1_in;

   always_comb begin
      a_exp = req_tdata[62:48];
      b_exp = req_tdata[190:176];
      a_frac = {req_tdata[47:0], req_tdata[127:64]};
      b_frac = {req_tdata[175:128], req_tdata[255:192]};
      a_nan = (a_exp == EXP_MAX) && (a_frac != '0);
      b_nan = (b_exp == EXP_MAX) && (b_frac != '0);
      a_inf = (a_exp == EXP_MAX) && (a_frac == '0);
      b_inf = (b_exp == EXP_MAX) && (b_frac == '0);
      a_zero = (a_exp == '0) && (a_frac == '0);
      b_zero = (b_exp == '0) && (b_frac == '0);
      ma_in = {15'd0, (a_exp != '0), a_frac};
      mb_in = {15'd0, (b_exp != '0), b_frac};
      lza_in = lead_zeros(ma_in);
      lzb_in = lead_zeros(mb_in);
      c1_in.sign = req_tdata[63] ^ req_tdata[191];
      c1_in.spec = a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
      priority if (a_nan) begin
         c1_in.spec_val = {1'b0, a_exp, 1'b1, a_frac[110:0]};
      end else if (b_nan) begin
         c1_in.spec_val = {1'b0, b_exp, 1'b1, b_frac[110:0]};
      end else if (a_inf || b_inf) begin
         c1_in.spec_val = (a_zero || b_zero) ? QNAN_VAL : INF_VAL;
      end else begin
         c1_in.spec_val = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         c_ff[1] <= c1_in;
         s1_ma_ff <= ma_in;
         s1_mb_ff <= mb_in;
         s1_lza_ff <= lza_in;
         s1_lzb_ff <= lzb_in;
         s1_ea_ff <= (a_exp != '0) ? EXP_W'({3'd0, a_exp})
                                   : EXP_W'(18'sd16 - EXP_W'({11'd0, lza_in}));
         s1_eb_ff <= (b_exp != '0) ? EXP_W'({3'd0, b_exp})
                                   : EXP_W'(18'sd16 - EXP_W'({11'd0, lzb_in}));
      end
   end

   // stage 2: normalize significands
   always_ff @(posedge clock) begin
      if (en[2]) begin
         c_ff[2] <= c_ff[1];
         s2_x_ff <= s1_ma_ff << s1_lza_ff;
         s2_y_ff <= s1_mb_ff << s1_lzb_ff;
         s2_e_ff <= s1_ea_ff + s1_eb_ff - EXP_BIAS;
      end
   end

   // stage 3: partial products
   always_ff @(posedge clock) begin
      if (en[3]) begin
         c_ff[3] <= c_ff[2];
         s3_e_ff <= s2_e_ff;
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               s3_pp_ff[i][j] <= 64'(s2_x_ff[32*i +: 32]) * 64'(s2_y_ff[32*j +: 32]);
            end
         end
      end
   end

   // stage 4: column sums
   logic [65:0] col_in [7];
   always_comb begin
      for (int k = 0; k < 7; k++) begin
         col_in[k] = '0;
         for (int i = 0; i < 4; i++) begin
            if (k - i >= 0 && k - i < 4) begin
               col_in[k] = col_in[k] + 66'(s3_pp_ff[i][k-i]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         c_ff[4] <= c_ff[3];
         s4_e_ff <= s3_e_ff;
         s4_col_ff <= col_in;
      end
   end

   // stage 5: even and odd column groups
   always_ff @(posedge clock) begin
      if (en[5]) begin
         c_ff[5] <= c_ff[4];
         s5_e_ff <= s4_e_ff;
         s5_even_ff <= 256'(s4_col_ff[0]) + (256'(s4_col_ff[2]) << 64)
                     + (256'(s4_col_ff[4]) << 128) + (256'(s4_col_ff[6]) << 192);
         s5_odd_ff <= (256'(s4_col_ff[1]) << 32) + (256'(s4_col_ff[3]) << 96)
                    + (256'(s4_col_ff[5]) << 160);
      end
   end

   // stage 6: full product
   always_ff @(posedge clock) begin
      if (en[6]) begin
         c_ff[6] <= c_ff[5];
         s6_e_ff <= s5_e_ff;
         s6_z_ff <= s5_even_ff + s5_odd_ff;
      end
   end

   // stage 7: align product, fold low half into sticky
   logic [127:0] sig_in;
   always_comb begin
      sig_in = {s6_z_ff[255:129], s6_z_ff[128] | (s6_z_ff[127:0] != '0)};
      if (!s6_z_ff[255]) begin
         sig_in = sig_in << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         c_ff[7] <= c_ff[6];
         s7_sig_ff <= sig_in;
         s7_e_ff <= s6_e_ff + EXP_W'({17'd0, s6_z_ff[255]});
      end
   end

   // stage 8: rounding decision
   logic [127:0] t_sh, r_sub, rem_sub, r_in;
   logic [15:0] low_bits;
   logic [6:0] n_sub;
   logic [EXP_W-1:0] e_neg;
   logic inc_in, sticky;

   always_comb begin
      t_sh = s7_sig_ff << 1;
      low_bits = t_sh[15:0];
      e_neg = EXP_W'(-s7_e_ff);
      n_sub = e_neg[6:0];
      r_sub = s7_sig_ff >> (8'd16 + {1'b0, n_sub});
      rem_sub = s7_sig_ff << (8'd112 - {1'b0, n_sub});
      sticky = r_sub[0] || (rem_sub[63:0] != '0);
      priority if (s7_e_ff >= EXP_INF) begin
         r_in = INF_VAL;
         inc_in = 1'b0;
      end else if (s7_e_ff > 18'sd0) begin
         r_in = {s7_e_ff[15:0], t_sh[127:16]};
         inc_in = (low_bits > HALF_ULP) || ((low_bits == HALF_ULP) && t_sh[16]);
      end else if (s7_e_ff >= EXP_TINY) begin
         r_in = r_sub;
         inc_in = rem_sub[127] && ((rem_sub[126:64] != '0) || sticky);
      end else begin
         r_in = '0;
         inc_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         c_ff[8] <= c_ff[7];
         s8_r_ff <= r_in;
         s8_inc_ff <= inc_in;
      end
   end

   // stage 9: increment and result select
   always_ff @(posedge clock) begin
      if (en[9]) begin
         c_ff[9] <= c_ff[8];
         s9_r_ff <= c_ff[8].spec ? c_ff[8].spec_val : s8_r_ff + 128'(s8_inc_ff);
      end
   end

   assign rsp_tvalid = v_ff[NSTAGE];
   assign rsp_tdata = {s9_r_ff[63:0], c_ff[NSTAGE].sign, s9_r_ff[126:64]};

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[4] && !en[4] |=> v_ff[4] && $stable(s4_col_ff[0]))
      else $error("stalled stage lost its transaction");
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v_ff == '1) && !rsp_tready)
      else $error("input stalled with an empty stage");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
`endif

endmodule

// ----- verif/tb_binary128_float_multiply.sv -----
// testbench for the pipelined binary128 multiplier: random and corner-case operand streams
`timescale 1ns / 1ps

module tb_binary128_float_multiply;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [255:0] req_tdata;   // a_hi, a_lo, b_hi, b_lo
   logic rsp_tvalid;
   logic rsp_tready;
   logic [127:0] rsp_tdata;   // product_hi, product_lo

   localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
   localparam logic [63:0] INF_HI = 64'h7FFF_0000_0000_0000;
   localparam logic [63:0] QUIET_BIT = 64'h0000_8000_0000_0000;
   localparam logic [63:0] FRAC_MASK = 64'h0000_FFFF_FFFF_FFFF;
   localparam int N_RANDOM = 1280;
   localparam int CYCLE_LIMIT = 400000;

   binary128_float_multiply dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   logic [255:0] pending_ops[$];
   logic [127:0] expected_products[$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int cycles = 0;
   int send_gap = 0;
   int recv_gap = 0;
   bit stimulus_done = 0;
   bit req_taken = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // normalized significand, leading one at bit 112, with biased exponent
   function automatic int unpack_operand(input logic [63:0] hi, input logic [63:0] lo,
                                         output logic [112:0] sig);
      int e;
      logic [127:0] m;
      int p;
      e = int'(hi[62:48]);
      m = {hi & FRAC_MASK, lo};
      if (e == 0) begin
         p = 0;
         for (int i = 0; i < 112; i++) if (m[i]) p = i;
         m = m << (112 - p);
         e = 1 - (112 - p);
      end else begin
         m[112] = 1'b1;
      end
      sig = m[112:0];
      return e;
   endfunction

   function automatic logic [127:0] multiply_binary128(input logic [255:0] ops);
      logic [63:0] ah, al, bh, bl, sgn;
      logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [127:0] res;
      logic [112:0] x, y;
      logic [225:0] prod;
      logic [112:0] kept;
      logic [127:0] shifted;
      logic guard, sticky;
      int e, n;
      ah = ops[63:0] & ~SIGN_BIT;
      al = ops[127:64];
      bh = ops[191:128] & ~SIGN_BIT;
      bl = ops[255:192];
      sgn = (ops[63:0] ^ ops[191:128]) & SIGN_BIT;
      a_nan = ah > INF_HI || (ah == INF_HI && al != 0);
      b_nan = bh > INF_HI || (bh == INF_HI && bl != 0);
      a_inf = ah == INF_HI && al == 0;
      b_inf = bh == INF_HI && bl == 0;
      a_zero = ah == 0 && al == 0;
      b_zero = bh == 0 && bl == 0;
      res = '0;
      if (a_nan) res = {ah | QUIET_BIT, al};
      else if (b_nan) res = {bh | QUIET_BIT, bl};
      else if (a_inf || b_inf) res = {(a_zero || b_zero) ? (INF_HI | QUIET_BIT) : INF_HI, 64'd0};
      else if (!a_zero && !b_zero) begin
         e = unpack_operand(ah, al, x) + unpack_operand(bh, bl, y) - 16383;
         prod = x * y;
         if (prod[225]) e = e + 1;
         else prod = prod << 1;
         // leading one now at bit 225, 112 fraction bits below it
         if (e >= 32767) res = {INF_HI, 64'd0};
         else if (e > 0) begin
            kept = prod[225:113];
            guard = prod[112];
            sticky = |prod[111:0];
            res = {e[14:0], kept[111:0]};
            if (guard && (sticky || kept[0])) res = res + 1;
         end else if (e >= -112) begin
            n = 1 - e;
            shifted = {2'b0, prod[225:100]} >> n;
            guard = shifted[12];
            sticky = 0;
            for (int i = 0; i < 126; i++) if (i + 100 < n + 112 && prod[100 + i]) sticky = 1;
            sticky = sticky || |prod[99:0];
            res = shifted[127:13];
            if (guard && (sticky || res[0])) res = res + 1;
         end
      end
      res[127] = res[127] | sgn[63];
      return res;
   endfunction

   function automatic logic [127:0] pick_operand();
      logic [63:0] hi, lo;
      int k;
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      k = $urandom_range(0, 99);
      if (k < 55) hi[62:48] = 15'(16383 + $urandom_range(0, 200) - 100);
      else if (k < 65) hi[62:48] = 15'($urandom_range(0, 3));
      else if (k < 72) hi[62:48] = 15'($urandom_range(32760, 32767));
      else if (k < 80) hi[62:48] = 15'(16383 - 8200 + $urandom_range(0, 200));
      else if (k < 86) hi[62:48] = 15'(16383 + 8100 + $urandom_range(0, 200));
      else if (k < 90) begin
         hi[62:48] = 0;
         if ($urandom_range(0, 1)) hi[47:0] = 0;
         else lo = 64'(1) << $urandom_range(0, 63);
      end else if (k < 94) begin
         hi[62:48] = 15'h7FFF;
         if ($urandom_range(0, 1)) begin hi[47:0] = 0; lo = 0; end
      end else if (k < 97) begin
         hi[62:0] = 0;
         lo = 0;
      end
      if ($urandom_range(0, 3) == 0) lo[15:0] = $urandom_range(0, 1) ? 16'h8000 : 16'h0;
      return {lo, hi};
   endfunction

   task automatic queue_op(input logic [63:0] ah, al, bh, bl);
      pending_ops.push_back({bl, bh, al, ah});
   endtask

   initial begin
      logic [127:0] opa, opb;
      // zeros, infinities, nans, extremes, subnormals, overflow, underflow, ties
      queue_op(64'h3FFF_0000_0000_0000, 0, 64'h4000_0000_0000_0000, 0);
      queue_op(64'h8000_0000_0000_0000, 0, 64'h3FFF_0000_0000_0000, 0);
      queue_op(64'h7FFF_0000_0000_0000, 0, 64'h0, 0);
      queue_op(64'h0, 0, 64'hFFFF_0000_0000_0000, 0);
      queue_op(64'hFFFF_0000_0000_0000, 0, 64'hBFFF_0000_0000_0000, 0);
      queue_op(64'h7FFF_0000_0000_0001, 5, 64'h7FFF_8000_0000_0000, 7);
      queue_op(64'h3FFF_0000_0000_0000, 0, 64'hFFFF_0000_0000_0000, 1);
      queue_op(64'h7FFF_FFFF_FFFF_FFFF, '1, 64'h3FFF_0000_0000_0000, 0);
      queue_op(64'h7FFE_FFFF_FFFF_FFFF, '1, 64'h7FFE_FFFF_FFFF_FFFF, '1);
      queue_op(64'h7FFE_FFFF_FFFF_FFFF, '1, 64'h3FFF_0000_0000_0000, '1);
      queue_op(64'h0, 1, 64'h3FFF_0000_0000_0000, 0);
      queue_op(64'h0, 1, 64'h3FFE_0000_0000_0000, 0);
      queue_op(64'h0, 1, 64'h3FFE_0000_0000_0000, 1);
      queue_op(64'h0, 1, 64'h0, 1);
      queue_op(64'h0000_FFFF_FFFF_FFFF, '1, 64'h4000_0000_0000_0000, 0);
      queue_op(64'h0001_0000_0000_0000, 0, 64'h3FFE_0000_0000_0000, 0);
      queue_op(64'h0001_0000_0000_0000, 0, 64'h3FFF_FFFF_FFFF_FFFF, '1);
      queue_op(64'h0001_0000_0000_0000, 3, 64'h3F8E_0000_0000_0000, 0);
      queue_op(64'h3FFF_0000_0000_0000, 1, 64'h3FFF_0000_0000_0000, 64'h8000_0000_0000_0000);
      queue_op(64'h3FFF_FFFF_FFFF_FFFF, '1, 64'hBFFF_FFFF_FFFF_FFFF, '1);
      queue_op(64'h0000_8000_0000_0000, 0, 64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000);
      queue_op(64'h7FFF_0000_0000_0000, 0, 64'h0000_0000_0000_0000, 1);
      for (int i = 0; i < N_RANDOM; i++) begin
         opa = pick_operand();
         opb = pick_operand();
         if (i < 8) begin opa = '1; opb = (i % 2) ? '1 : '0; end
         pending_ops.push_back({opb, opa});
      end
   end

   // drive on falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (send_gap > 0 || pending_ops.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_ops.pop_front();
               send_gap = (sent % 300 < 100) ? 0 : pick_gap();
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap = (cycles % 4000 < 1200) ? 0 : pick_gap();
         end
      end
   end

   // check on rising edge
   always @(posedge clock) begin
      logic [127:0] want;
      cycles++;
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         expected_products.push_back(multiply_binary128(req_tdata));
         sent++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         received++;
         if (expected_products.size() == 0) begin
            $error("unexpected product transaction %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_products.pop_front();
            if (want[127:64] != rsp_tdata[63:0]) begin
               $error("product_hi expected %h actual %h", want[127:64], rsp_tdata[63:0]);
               errors++;
            end
            if (want[63:0] != rsp_tdata[127:64]) begin
               $error("product_lo expected %h actual %h", want[63:0], rsp_tdata[127:64]);
               errors++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while ((pending_ops.size() != 0 || req_tvalid || expected_products.size() != 0)
             && cycles < CYCLE_LIMIT)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_binary128_float_multiply: FAIL");
      end else begin
         $display("multiplied %0d operand pairs, %0d products checked", sent, received);
         $display("covered nan, infinity, zero, subnormal, overflow and rounding ties");
         if (errors == 0 && expected_products.size() == 0) begin
            $display("tb_binary128_float_multiply: PASS");
         end else begin
            $display("tb_binary128_float_multiply: FAIL");
         end
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/bf128m_pkg.sv
hdl/binary128_float_multiply.sv
verif/tb_binary128_float_multiply.sv
